>>> hdl/flv_fr_pkg.sv
// Shared types and constants for the FLV tag framer.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package flv_fr_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int SIZE_W   = 25;
    localparam int STAMP_W  = 24;
    localparam int IDENT_W  = 24;
    localparam int FLAGS_W  = 8;
    localparam int CTIME_W  = 24;
    localparam int CFG_IDX_W = 1;

    // Longest byte run caused by one item: tag header, 5 media bytes, trailer
    localparam int FRAME_MAX = 20;
    localparam int LEN_W     = 5;

    // Request codes
    typedef enum logic [1:0] {
        REQ_FILE    = 2'd0,
        REQ_AUDIO   = 2'd1,
        REQ_VIDEO   = 2'd2,
        REQ_PAYLOAD = 2'd3
    } t_req;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_IDENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS = 1'b1;

    localparam logic [FLAGS_W-1:0] HEADER_FLAGS_RST = 8'd5;

    // Stream constants
    localparam logic [BYTE_W-1:0] SIG_F       = 8'h46;
    localparam logic [BYTE_W-1:0] SIG_L       = 8'h4c;
    localparam logic [BYTE_W-1:0] SIG_V       = 8'h56;
    localparam logic [BYTE_W-1:0] FLV_VERSION = 8'h01;
    localparam logic [BYTE_W-1:0] FILE_HDR_SZ = 8'd9;
    localparam logic [BYTE_W-1:0] TAG_AUDIO   = 8'd8;
    localparam logic [BYTE_W-1:0] TAG_VIDEO   = 8'd9;
    localparam logic [3:0]        FMT_AAC     = 4'd10;
    localparam logic [3:0]        CODEC_AVC   = 4'd7;
    localparam logic [23:0]       TAG_HDR_SUB = 24'd11;

    // Run lengths
    localparam logic [LEN_W-1:0] LEN_FILE    = 5'd13;
    localparam logic [LEN_W-1:0] LEN_TAG_HDR = 5'd11;
    localparam logic [LEN_W-1:0] LEN_TRAILER = 5'd4;
    localparam logic [LEN_W-1:0] LEN_ONE     = 5'd1;

    // Byte run built for one item; byte 0 goes out first
    typedef struct packed {
        logic [FRAME_MAX-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]                 len;
        logic                             trail;
    } t_frame;

    // Open-tag bookkeeping
    typedef struct packed {
        logic              in_tag;
        logic [SIZE_W-1:0] size;
    } t_tag_state;

endpackage

`default_nettype wire

>>> hdl/flv_fr_ifs.sv
// Handshake channel interfaces of the FLV tag framer: request items,
// stream bytes and configuration writes. Depends on flv_fr_pkg.
`default_nettype none

interface flv_fr_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic [flv_fr_pkg::SIZE_W-1:0]   tag_size;
    logic [flv_fr_pkg::STAMP_W-1:0]  stamp_low;
    logic [7:0]                      stamp_high;
    logic [3:0]                      format_code;
    logic [3:0]                      codec_code;
    logic                            sample_wide;
    logic                            stereo_flag;
    logic [7:0]                      packet_kind;
    logic [flv_fr_pkg::CTIME_W-1:0]  comp_time;
    logic [7:0]                      payload_byte;
    logic                            final_flag;

    modport source (
        output valid, req_type, tag_size, stamp_low, stamp_high, format_code,
               codec_code, sample_wide, stereo_flag, packet_kind, comp_time,
               payload_byte, final_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, tag_size, stamp_low, stamp_high, format_code,
               codec_code, sample_wide, stereo_flag, packet_kind, comp_time,
               payload_byte, final_flag,
        output ready
    );
endinterface

interface flv_fr_out_if;
    logic                           valid;
    logic                           ready;
    logic [flv_fr_pkg::BYTE_W-1:0]  out_byte;
    logic                           run_last;
    logic                           tag_done;

    modport source (output valid, out_byte, run_last, tag_done, input ready);
    modport sink   (input valid, out_byte, run_last, tag_done, output ready);
endinterface

interface flv_fr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [flv_fr_pkg::CFG_IDX_W-1:0]   index;
    logic [flv_fr_pkg::IDENT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/flv_tag_framer_top.sv
// FLV tag framer: request items in, FLV stream bytes out, configuration writes.
// Depends on flv_fr_pkg, flv_fr_ifs, flv_fr_build and flv_fr_serial.
//
// Usage:
//   i_item carries one request per item: file header, audio or video tag
//   start, or one payload byte. o_res carries the stream one byte per item,
//   with run_last on the final byte of a request's run and tag_done on the
//   last byte of a trailing tag size. i_cfg writes the stream id (index 0)
//   and the file-header flag byte (index 1); it is always ready.
// Timing:
//   An accepted request is turned into its whole byte run in the same cycle
//   and loaded into a run buffer; its first byte moves from the buffer to the
//   output register before it shows on o_res. The next request is taken
//   in the cycle the last byte leaves the buffer: payload bytes flow at one
//   per cycle while o_res.ready is high. A tag-start run is 12 to 20 bytes,
//   a file header 13. A payload byte outside a tag is taken with no output.
// Reset (synchronous, active low): no tag open, latched size 0, stream id 0,
//   header flags 5, buffer and output empty.
// Stall: when o_res.ready is low the output register holds its byte, the
//   buffer holds the rest of the run, and i_item.ready drops once the buffer
//   is occupied.
`default_nettype none

module flv_tag_framer_top (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    flv_fr_in_if.sink     i_item,
    flv_fr_out_if.source  o_res,
    flv_fr_cfg_if.sink    i_cfg
);

    logic [flv_fr_pkg::IDENT_W-1:0] r_stream_ident;
    logic [flv_fr_pkg::FLAGS_W-1:0] r_header_flags;
    flv_fr_pkg::t_tag_state         r_state;
    flv_fr_pkg::t_tag_state         n_state;
    flv_fr_pkg::t_frame             frame;
    logic                           can_take;
    logic                           accept;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = can_take;
    assign accept       = i_item.valid && can_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_ident <= '0;
            r_header_flags <= flv_fr_pkg::HEADER_FLAGS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                flv_fr_pkg::CFG_STREAM_IDENT: r_stream_ident <= i_cfg.data;
                flv_fr_pkg::CFG_HEADER_FLAGS:
                    r_header_flags <= i_cfg.data[flv_fr_pkg::FLAGS_W-1:0];
                default: ;
            endcase
        end
    end

    // Open-tag state advances with every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    flv_fr_build u_build (
        .i_req_type     (i_item.req_type),
        .i_tag_size     (i_item.tag_size),
        .i_stamp_low    (i_item.stamp_low),
        .i_stamp_high   (i_item.stamp_high),
        .i_format_code  (i_item.format_code),
        .i_codec_code   (i_item.codec_code),
        .i_sample_wide  (i_item.sample_wide),
        .i_stereo_flag  (i_item.stereo_flag),
        .i_packet_kind  (i_item.packet_kind),
        .i_comp_time    (i_item.comp_time),
        .i_payload_byte (i_item.payload_byte),
        .i_final_flag   (i_item.final_flag),
        .i_stream_ident (r_stream_ident),
        .i_header_flags (r_header_flags),
        .i_state        (r_state),
        .o_frame        (frame),
        .o_state        (n_state)
    );

    flv_fr_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept && (frame.len != '0)),
        .i_frame     (frame),
        .o_can_take  (can_take),
        .i_out_ready (o_res.ready),
        .o_valid     (o_res.valid),
        .o_byte      (o_res.out_byte),
        .o_last      (o_res.run_last),
        .o_done      (o_res.tag_done)
    );

endmodule

`default_nettype wire

>>> hdl/flv_fr_build.sv
// Builds the byte run that one request item causes, plus the next open-tag state.
// Purely combinational. Depends on flv_fr_pkg.
`default_nettype none

module flv_fr_build (
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [flv_fr_pkg::SIZE_W-1:0]   i_tag_size,
    input  wire logic [flv_fr_pkg::STAMP_W-1:0]  i_stamp_low,
    input  wire logic [7:0]                      i_stamp_high,
    input  wire logic [3:0]                      i_format_code,
    input  wire logic [3:0]                      i_codec_code,
    input  wire logic                            i_sample_wide,
    input  wire logic                            i_stereo_flag,
    input  wire logic [7:0]                      i_packet_kind,
    input  wire logic [flv_fr_pkg::CTIME_W-1:0]  i_comp_time,
    input  wire logic [7:0]                      i_payload_byte,
    input  wire logic                            i_final_flag,
    input  wire logic [flv_fr_pkg::IDENT_W-1:0]  i_stream_ident,
    input  wire logic [flv_fr_pkg::FLAGS_W-1:0]  i_header_flags,
    input  wire flv_fr_pkg::t_tag_state          i_state,
    output flv_fr_pkg::t_frame                   o_frame,
    output flv_fr_pkg::t_tag_state               o_state
);

    flv_fr_pkg::t_req   req;
    logic [31:0]        trl_new;
    logic [31:0]        trl_old;
    logic [23:0]        body_size;
    logic [4:0][7:0]    media;
    logic [2:0]         media_len;
    logic [8:0][7:0]    tail;

    assign req       = flv_fr_pkg::t_req'(i_req_type);
    assign trl_new   = {7'd0, i_tag_size};
    assign trl_old   = {7'd0, i_state.size};
    assign body_size = i_tag_size[23:0] - flv_fr_pkg::TAG_HDR_SUB;

    // Media header bytes of a tag start
    always_comb begin
        media     = '0;
        media_len = 3'd1;
        if (req == flv_fr_pkg::REQ_AUDIO) begin
            media[0] = {i_format_code, i_codec_code[1:0], i_sample_wide, i_stereo_flag};
            media[1] = i_packet_kind;
            if (i_format_code == flv_fr_pkg::FMT_AAC) begin
                media_len = 3'd2;
            end
        end else begin
            media[0] = {i_format_code, i_codec_code};
            media[1] = i_packet_kind;
            media[2] = i_comp_time[23:16];
            media[3] = i_comp_time[15:8];
            media[4] = i_comp_time[7:0];
            if (i_codec_code == flv_fr_pkg::CODEC_AVC) begin
                media_len = 3'd5;
            end
        end
    end

    // Media bytes followed directly by the trailing tag size
    always_comb begin
        tail = '0;
        case (media_len)
            3'd2: begin
                tail[0] = media[0];
                tail[1] = media[1];
                tail[2] = trl_new[31:24];
                tail[3] = trl_new[23:16];
                tail[4] = trl_new[15:8];
                tail[5] = trl_new[7:0];
            end
            3'd5: begin
                tail[0] = media[0];
                tail[1] = media[1];
                tail[2] = media[2];
                tail[3] = media[3];
                tail[4] = media[4];
                tail[5] = trl_new[31:24];
                tail[6] = trl_new[23:16];
                tail[7] = trl_new[15:8];
                tail[8] = trl_new[7:0];
            end
            default: begin
                tail[0] = media[0];
                tail[1] = trl_new[31:24];
                tail[2] = trl_new[23:16];
                tail[3] = trl_new[15:8];
                tail[4] = trl_new[7:0];
            end
        endcase
    end

    // Whole run per request kind
    always_comb begin
        o_frame = '0;
        o_state = i_state;
        case (req)
            flv_fr_pkg::REQ_FILE: begin
                o_frame.bytes[0] = flv_fr_pkg::SIG_F;
                o_frame.bytes[1] = flv_fr_pkg::SIG_L;
                o_frame.bytes[2] = flv_fr_pkg::SIG_V;
                o_frame.bytes[3] = flv_fr_pkg::FLV_VERSION;
                o_frame.bytes[4] = i_header_flags;
                o_frame.bytes[8] = flv_fr_pkg::FILE_HDR_SZ;
                o_frame.len      = flv_fr_pkg::LEN_FILE;
                o_state.in_tag   = 1'b0;
            end
            flv_fr_pkg::REQ_PAYLOAD: begin
                // outside a tag the byte is dropped: empty run
                if (i_state.in_tag) begin
                    o_frame.bytes[0] = i_payload_byte;
                    o_frame.bytes[1] = trl_old[31:24];
                    o_frame.bytes[2] = trl_old[23:16];
                    o_frame.bytes[3] = trl_old[15:8];
                    o_frame.bytes[4] = trl_old[7:0];
                    o_frame.len      = flv_fr_pkg::LEN_ONE;
                    if (i_final_flag) begin
                        o_frame.len    = flv_fr_pkg::LEN_ONE + flv_fr_pkg::LEN_TRAILER;
                        o_frame.trail  = 1'b1;
                        o_state.in_tag = 1'b0;
                    end
                end
            end
            default: begin
                o_frame.bytes[0]  = (req == flv_fr_pkg::REQ_AUDIO) ?
                                    flv_fr_pkg::TAG_AUDIO : flv_fr_pkg::TAG_VIDEO;
                o_frame.bytes[1]  = body_size[23:16];
                o_frame.bytes[2]  = body_size[15:8];
                o_frame.bytes[3]  = body_size[7:0];
                o_frame.bytes[4]  = i_stamp_low[23:16];
                o_frame.bytes[5]  = i_stamp_low[15:8];
                o_frame.bytes[6]  = i_stamp_low[7:0];
                o_frame.bytes[7]  = i_stamp_high;
                o_frame.bytes[8]  = i_stream_ident[23:16];
                o_frame.bytes[9]  = i_stream_ident[15:8];
                o_frame.bytes[10] = i_stream_ident[7:0];
                for (int k = 0; k < 9; k++) begin
                    o_frame.bytes[11 + k] = tail[k];
                end
                o_frame.len   = flv_fr_pkg::LEN_TAG_HDR + {2'd0, media_len};
                o_frame.trail = i_final_flag;
                if (i_final_flag) begin
                    o_frame.len = flv_fr_pkg::LEN_TAG_HDR + {2'd0, media_len}
                                  + flv_fr_pkg::LEN_TRAILER;
                end
                o_state.size   = i_tag_size;
                o_state.in_tag = !i_final_flag;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/flv_fr_serial.sv
// Run buffer and output register: sends a built byte run one byte per cycle
// while the output is ready. Depends on flv_fr_pkg.
`default_nettype none

module flv_fr_serial (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire flv_fr_pkg::t_frame             i_frame,
    output logic                                o_can_take,
    input  wire logic                           i_out_ready,
    output logic                                o_valid,
    output logic [flv_fr_pkg::BYTE_W-1:0]       o_byte,
    output logic                                o_last,
    output logic                                o_done
);

    logic [flv_fr_pkg::FRAME_MAX-1:0][flv_fr_pkg::BYTE_W-1:0] r_buf;
    logic [flv_fr_pkg::LEN_W-1:0]                             r_left;
    logic                                                     r_trail;
    logic                                                     r_ov;
    logic [flv_fr_pkg::BYTE_W-1:0]                            r_obyte;
    logic                                                     r_olast;
    logic                                                     r_odone;
    logic                                                     move;
    logic                                                     last_move;

    // A byte moves to the output register when that register is free or draining
    assign move       = (r_left != '0) && (!r_ov || i_out_ready);
    assign last_move  = move && (r_left == flv_fr_pkg::LEN_ONE);
    assign o_can_take = (r_left == '0) || last_move;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (move) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            // a new run loads as the previous one sends its last byte
            if (i_load) begin
                r_left <= i_frame.len;
            end else if (move) begin
                r_left <= r_left - flv_fr_pkg::LEN_ONE;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_obyte <= r_buf[0];
            r_olast <= last_move;
            r_odone <= last_move && r_trail;
        end
        if (i_load) begin
            r_buf   <= i_frame.bytes;
            r_trail <= i_frame.trail;
        end else if (move) begin
            r_buf   <= r_buf >> flv_fr_pkg::BYTE_W;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_done  = r_odone;

endmodule

`default_nettype wire
